FILE: rtl/core/assert_macros.svh
// Assertion macros used by the RTL (rcc_back) of the RC frame CRC checker.
// Each macro checks on the rising edge of aclk and is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property prop must hold at every clock edge outside reset.
`define RCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Condition cond must never be true at a clock edge outside reset.
`define RCC_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

FILE: rtl/core/rcc_pkg.sv
// Shared constants, types and the CRC step function for the RC frame CRC checker.
// No dependencies; every RTL file of the block imports this package.
package rcc_pkg;

    localparam int CHANNELS      = 4;
    localparam int PAYLOAD_BYTES = 2 * CHANNELS;
    localparam int BYTE_IDX_W    = $clog2(PAYLOAD_BYTES);
    localparam int CH_IDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MAX_RESULTS   = 4;
    localparam int RES_CNT_W     = $clog2(MAX_RESULTS);
    localparam int JOB_Q_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(JOB_Q_DEPTH);

    localparam logic [7:0]  FRAME_MARKER = 8'hF7;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    // One checked frame handed from the parser to the result sequencer.
    typedef struct packed {
        logic                                crc_err;
        logic [PAYLOAD_BYTES-1:0][7:0]       bytes;
    } rcc_job_t;

    // Queue status seen by the parser and the sequencer.
    typedef struct packed {
        logic full;
        logic empty;
    } rcc_q_status_t;

    // One byte of the X.25 / MCRF4XX CRC-16.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
    endfunction

    // Channel index as it appears on the two-bit result field.
    function automatic logic [1:0] chan_code(input logic [CH_IDX_W-1:0] idx);
        logic [CH_IDX_W+1:0] w;
        w = {2'b00, idx};
        return w[1:0];
    endfunction

endpackage

FILE: rtl/core/rcc_front.sv
// Frame parser of the RC frame CRC checker: hunts for the marker, collects payload,
// runs the CRC and queues one job per frame that yields results. Uses rcc_pkg.
module rcc_front
    import rcc_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_rx_byte,
    input  rcc_q_status_t q_status,
    output logic          push,
    output rcc_job_t      push_job
);

    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_CRC_LO  = 2'd2;
    localparam logic [1:0] PH_CRC_HI  = 2'd3;

    logic [1:0]                    phase_reg, phase_next;
    logic [BYTE_IDX_W-1:0]         idx_reg, idx_next;
    logic [15:0]                   crc_reg, crc_next;
    logic [7:0]                    crc_lo_reg;
    logic [PAYLOAD_BYTES-1:0][7:0] payload_reg;
    logic                          accept;
    logic                          any_nonzero;

    // The final CRC byte is held back only while the job queue is full.
    assign s_ready = (phase_reg != PH_CRC_HI) || !q_status.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        any_nonzero = 1'b0;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            any_nonzero = any_nonzero || (payload_reg[i] != 8'h00);
        end
    end

    assign push_job.crc_err = ({s_rx_byte, crc_lo_reg} != crc_reg);
    assign push_job.bytes   = payload_reg;
    // A good frame whose periods are all zero gives nothing and is dropped here.
    assign push = accept && (phase_reg == PH_CRC_HI) && (push_job.crc_err || any_nonzero);

    always_comb begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        crc_next   = crc_reg;
        if (accept) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (s_rx_byte == FRAME_MARKER) begin
                        phase_next = PH_PAYLOAD;
                        idx_next   = '0;
                        crc_next   = CRC_INIT;
                    end
                end
                PH_PAYLOAD: begin
                    crc_next = crc_step(crc_reg, s_rx_byte);
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == BYTE_IDX_W'(PAYLOAD_BYTES - 1)) begin
                        phase_next = PH_CRC_LO;
                    end
                end
                PH_CRC_LO: begin
                    phase_next = PH_CRC_HI;
                end
                PH_CRC_HI: begin
                    phase_next = PH_HUNT;
                    idx_next   = '0;
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            idx_reg   <= '0;
            crc_reg   <= CRC_INIT;
        end else begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            crc_reg   <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (phase_reg == PH_PAYLOAD)) begin
            payload_reg[idx_reg] <= s_rx_byte;
        end
        if (accept && (phase_reg == PH_CRC_LO)) begin
            crc_lo_reg <= s_rx_byte;
        end
    end

endmodule

FILE: rtl/core/rcc_job_fifo.sv
// Short job queue between the frame parser and the result sequencer.
// Register based, depth JOB_Q_DEPTH from rcc_pkg.
module rcc_job_fifo
    import rcc_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  rcc_job_t      push_job,
    input  logic          pop,
    output rcc_job_t      pop_job,
    output rcc_q_status_t status
);

    rcc_job_t          mem_reg [JOB_Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign status.full  = (count_reg == (QPTR_W + 1)'(JOB_Q_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_job      = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(JOB_Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(JOB_Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            // A push and a pop in the same cycle leave the count as it is.
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: rtl/core/rcc_back.sv
// RC frame CRC checker result sequencer (uses rcc_pkg, assert_macros.svh): turns one queued
// job into an error result or up to MAX_RESULTS channel writes, one per cycle unless stalled.
`include "assert_macros.svh"

module rcc_back
    import rcc_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  rcc_q_status_t q_status,
    input  rcc_job_t      pop_job,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_result_kind,
    output logic [1:0]    m_channel,
    output logic [15:0]   m_period,
    output logic          m_newly_enabled,
    output logic          m_safety_release,
    output logic          m_last
);

    logic                           busy_reg;
    logic                           err_reg;
    logic [CHANNELS-1:0]            pending_reg, pending_next;
    logic [PAYLOAD_BYTES-1:0][7:0]  bytes_reg;
    logic [RES_CNT_W-1:0]           cnt_reg;
    logic [CHANNELS-1:0]            en_reg;
    logic                           m_valid_reg;
    logic                           kind_reg, newly_reg, rel_reg, last_reg;
    logic [1:0]                     chan_reg;
    logic [15:0]                    period_reg;

    logic                           slot_free;
    logic                           emit;
    logic [CH_IDX_W-1:0]            sel;
    logic [CHANNELS-1:0]            sel_bit;
    logic [BYTE_IDX_W-1:0]          sel_lo, sel_hi;
    logic [CHANNELS-1:0]            job_nonzero;
    logic                           last_w;

    assign slot_free = !m_valid_reg || m_ready;
    assign emit      = busy_reg && slot_free;
    assign pop       = !busy_reg && !q_status.empty;

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            job_nonzero[i] = ({pop_job.bytes[2*i+1], pop_job.bytes[2*i]} != 16'h0000);
        end
    end

    // Lowest pending channel goes out first.
    always_comb begin
        sel     = '0;
        sel_bit = '0;
        for (int i = CHANNELS - 1; i >= 0; i--) begin
            if (pending_reg[i]) begin
                sel     = CH_IDX_W'(i);
                sel_bit = CHANNELS'(1) << i;
            end
        end
    end

    // Byte positions of the selected channel's period.
    assign sel_lo = BYTE_IDX_W'({sel, 1'b0});
    assign sel_hi = BYTE_IDX_W'({sel, 1'b1});

    assign pending_next = pending_reg & ~sel_bit;
    assign last_w = err_reg || (pending_next == '0) ||
                    (cnt_reg == RES_CNT_W'(MAX_RESULTS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pending_reg <= '0;
            cnt_reg     <= '0;
            en_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (slot_free) begin
                m_valid_reg <= emit;
            end
            if (pop) begin
                busy_reg    <= 1'b1;
                pending_reg <= pop_job.crc_err ? '0 : job_nonzero;
                cnt_reg     <= '0;
            end else if (emit) begin
                pending_reg <= pending_next;
                cnt_reg     <= cnt_reg + 1'b1;
                if (last_w) begin
                    busy_reg <= 1'b0;
                end
                if (!err_reg) begin
                    en_reg <= en_reg | sel_bit;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            err_reg   <= pop_job.crc_err;
            bytes_reg <= pop_job.bytes;
        end
        if (emit) begin
            last_reg <= last_w;
            if (err_reg) begin
                kind_reg   <= KIND_ERROR;
                chan_reg   <= 2'b00;
                period_reg <= 16'h0000;
                newly_reg  <= 1'b0;
                rel_reg    <= 1'b0;
            end else begin
                kind_reg   <= KIND_WRITE;
                chan_reg   <= chan_code(sel);
                period_reg <= {bytes_reg[sel_hi], bytes_reg[sel_lo]};
                newly_reg  <= ((en_reg & sel_bit) == '0);
                rel_reg    <= (en_reg == '0);
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_result_kind    = kind_reg;
    assign m_channel        = chan_reg;
    assign m_period         = period_reg;
    assign m_newly_enabled  = newly_reg;
    assign m_safety_release = rel_reg;
    assign m_last           = last_reg;

    `RCC_ASSERT(a_err_is_last, m_valid_reg && (kind_reg == KIND_ERROR) |-> last_reg,
        "error result without last")
    `RCC_ASSERT(a_write_nonzero,
        m_valid_reg && (kind_reg == KIND_WRITE) |-> (period_reg != 16'h0000),
        "channel write with zero period")
    `RCC_ASSERT(a_release_is_new, m_valid_reg && rel_reg |-> newly_reg,
        "safety release on a channel that was already enabled")
    `RCC_NEVER(a_busy_no_work, busy_reg && !err_reg && (pending_reg == '0),
        "sequencer busy with no channel left to write")

endmodule

FILE: rtl/core/rc_frame_crc_checker_top.sv
// Top level of the RC frame CRC checker.
// Instantiates rcc_front, rcc_job_fifo and rcc_back; uses rcc_pkg.
//
// Usage: serial bytes enter one per beat on the s_ channel (s_valid, s_ready,
// s_rx_byte). Bytes are dropped until the 0xF7 marker; then 2*CHANNELS payload
// bytes (little-endian 16-bit periods) and a little-endian CRC-16 follow.
// Results leave on the m_ channel, one per beat. A bad CRC gives a single error
// beat; a good frame gives one write beat per nonzero channel, lowest channel
// first, at most four, with m_last on the final beat of the frame.
// Throughput: the parser takes one byte per cycle while s_ready is high. The sequencer
// loads a queued frame into its job registers and then gives one beat per cycle while
// m_ready allows; it takes no new frame until the last beat of the current one is
// registered. Two frames can be queued between parser and sequencer, and the parser
// stalls only its final CRC byte when that queue is full. The first result of a
// frame passes the job queue, the sequencer's job registers and the output register.
// Reset (aresetn low, synchronous) returns the parser to marker hunting, empties
// the queue, drops any pending results and forgets all enabled channels.
// A stalled receiver (m_ready low) holds the output register; the queue then
// absorbs frames until it fills, after which s_ready drops on a final CRC byte.
module rc_frame_crc_checker_top
    import rcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [1:0]  m_channel,
    output logic [15:0] m_period,
    output logic        m_newly_enabled,
    output logic        m_safety_release,
    output logic        m_last
);

    rcc_q_status_t q_status;
    rcc_job_t      push_job;
    rcc_job_t      pop_job;
    logic          push;
    logic          pop;

    // Front end: marker hunt, payload capture and CRC check.
    rcc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .q_status  (q_status),
        .push      (push),
        .push_job  (push_job)
    );

    // Decouples frame parsing from result delivery.
    rcc_job_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    // Back end: channel enable tracking and result beats.
    rcc_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_status         (q_status),
        .pop_job          (pop_job),
        .pop              (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_channel        (m_channel),
        .m_period         (m_period),
        .m_newly_enabled  (m_newly_enabled),
        .m_safety_release (m_safety_release),
        .m_last           (m_last)
    );

endmodule
